// ===== design/mrop_pkg.sv =====
// Package for the maximum row overlap pair finder.
// Holds the sequencer state type, field widths and the popcount function.
// Depends on nothing; the pair finder unit and the checker import it.
package mrop_pkg;

  localparam int unsigned ROW_W = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 6;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_RDI,
    S_LATI,
    S_PAIR,
    S_OUT
  } state_e;

  // Number of ones in one row word.
  function automatic logic [CNT_W-1:0] ones_in(input logic [ROW_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < ROW_W; k++) begin
      n = n + CNT_W'(v[k]);
    end
    return n;
  endfunction

endpackage

// ===== design/mrop_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the row store of the pair finder; needs no package.
module mrop_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/max_row_overlap_pair_finder_unit.sv =====
// Maximum row overlap pair finder: loads a square bit matrix one row per beat
// and reports the row pair with the most shared one columns.
// Throughput: a row that is not the last is taken every cycle. After the last
// row the input stalls while the unit scans every row pair; each new first
// row is read and latched, then one pair is checked per cycle.
// Reset (rst_ni low, asynchronous) empties the matrix and drops any result.
module max_row_overlap_pair_finder_unit #(
  parameter int unsigned MAX_N = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mrop_pkg::ROW_W-1:0]  row_bits_i,
  input  logic                        last_row_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [mrop_pkg::IDX_W-1:0]  heavier_row_o,
  output logic [mrop_pkg::IDX_W-1:0]  lighter_row_o,
  output logic [mrop_pkg::CNT_W-1:0]  overlap_count_o,
  output logic [mrop_pkg::ROW_W-1:0]  common_mask_o
);

  import mrop_pkg::*;

  // Row counts run from 0 to MAX_N; store addresses from 0 to MAX_N-1.
  localparam int unsigned CW = $clog2(MAX_N + 1);
  localparam int unsigned AW = $clog2(MAX_N);

  state_e state_q, state_d;

  logic [CW-1:0]    rows_q, rows_d;
  logic [CW-1:0]    i_q, i_d;
  logic [CW-1:0]    j_q, j_d;
  logic [ROW_W-1:0] ri_q, ri_d;
  logic [CNT_W-1:0] wi_q, wi_d;
  logic [CNT_W-1:0] best_count_q, best_count_d;
  logic [CW-1:0]    best_hi_q, best_hi_d;
  logic [CW-1:0]    best_lo_q, best_lo_d;
  logic [ROW_W-1:0] best_mask_q, best_mask_d;

  logic             out_valid_q, out_valid_d;
  logic             found_q;
  logic [IDX_W-1:0] heavier_q, lighter_q;
  logic [CNT_W-1:0] count_q;
  logic [ROW_W-1:0] mask_q;

  logic             in_acc;
  logic             out_free;
  logic             emit;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [ROW_W-1:0] ram_rdata;

  logic [6:0]       n_ext;
  logic [ROW_W-1:0] col_mask;
  logic [ROW_W-1:0] rj_masked;
  logic [ROW_W-1:0] common;
  logic [ROW_W-1:0] pc_a_in;
  logic [CNT_W-1:0] pc_a;
  logic [CNT_W-1:0] pc_common;
  logic [CW-1:0]    j_next;
  logic             j_more;
  logic             i_more;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Rows beyond the store depth are dropped; only the count saturates.
  assign ram_we = in_acc && (rows_q < CW'(MAX_N));

  mrop_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_N)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rows_q[AW-1:0]),
    .wdata_i (row_bits_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Only columns below the row count exist, so the matrix stays square.
  assign n_ext    = 7'(rows_q);
  assign col_mask = (n_ext >= 7'd32) ? '1 : ((32'd1 << n_ext) - 32'd1);

  // The shared count unit: one word weight and one overlap count per cycle.
  // While a first row arrives it weighs that row; during pair checks it weighs
  // the second row and counts the common columns.
  assign rj_masked = ram_rdata & col_mask;
  assign common    = ri_q & rj_masked;
  assign pc_a_in   = (state_q == S_LATI) ? rj_masked : rj_masked;
  assign pc_a      = ones_in(pc_a_in);
  assign pc_common = ones_in(common);

  assign j_next = j_q + CW'(1);
  assign j_more = j_next < rows_q;
  assign i_more = ((CW + 1)'(i_q) + (CW + 1)'(2)) < (CW + 1)'(rows_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc && last_row_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = (rows_q < CW'(2)) ? S_OUT : S_RDI;
      end
      S_RDI: begin
        state_d = S_LATI;
      end
      S_LATI: begin
        state_d = S_PAIR;
      end
      S_PAIR: begin
        if (!j_more) begin
          state_d = i_more ? S_RDI : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Datapath control and best-pair tracking.
  always_comb begin
    rows_d       = rows_q;
    i_d          = i_q;
    j_d          = j_q;
    ri_d         = ri_q;
    wi_d         = wi_q;
    best_count_d = best_count_q;
    best_hi_d    = best_hi_q;
    best_lo_d    = best_lo_q;
    best_mask_d  = best_mask_q;
    ram_re       = 1'b0;
    ram_raddr    = i_q[AW-1:0];
    emit         = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (ram_we) begin
          rows_d = rows_q + CW'(1);
        end
      end
      S_START: begin
        i_d          = '0;
        best_count_d = '0;
        best_hi_d    = '0;
        best_lo_d    = '0;
        best_mask_d  = '0;
      end
      S_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = i_q[AW-1:0];
        j_d       = i_q + CW'(1);
      end
      S_LATI: begin
        // Row i arrives; keep it with its weight and fetch the first partner.
        ri_d      = rj_masked;
        wi_d      = pc_a;
        ram_re    = 1'b1;
        ram_raddr = j_q[AW-1:0];
      end
      S_PAIR: begin
        // Row j_q arrives. A strictly larger overlap replaces the best pair.
        if (pc_common > best_count_q) begin
          best_count_d = pc_common;
          best_mask_d  = common;
          if (wi_q < pc_a) begin
            best_hi_d = j_q;
            best_lo_d = i_q;
          end else begin
            best_hi_d = i_q;
            best_lo_d = j_q;
          end
        end
        if (j_more) begin
          ram_re    = 1'b1;
          ram_raddr = j_next[AW-1:0];
          j_d       = j_next;
        end else begin
          i_d = i_q + CW'(1);
        end
      end
      S_OUT: begin
        if (out_free) begin
          emit   = 1'b1;
          rows_d = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      rows_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; the best pair is cleared at each scan.
  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    ri_q         <= ri_d;
    wi_q         <= wi_d;
    best_count_q <= best_count_d;
    best_hi_q    <= best_hi_d;
    best_lo_q    <= best_lo_d;
    best_mask_q  <= best_mask_d;
    if (emit) begin
      found_q   <= (best_count_q != '0);
      heavier_q <= IDX_W'(best_hi_q);
      lighter_q <= IDX_W'(best_lo_q);
      count_q   <= best_count_q;
      mask_q    <= best_mask_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign heavier_row_o   = heavier_q;
  assign lighter_row_o   = lighter_q;
  assign overlap_count_o = count_q;
  assign common_mask_o   = mask_q;

endmodule

// ===== design/mrop_checker.sv =====
// Port-level checks for the maximum row overlap pair finder.
// Imports mrop_pkg for field widths; bound to the top level below.
module mrop_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [mrop_pkg::ROW_W-1:0]  row_bits_i,
  input logic                        last_row_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        found_o,
  input logic [mrop_pkg::IDX_W-1:0]  heavier_row_o,
  input logic [mrop_pkg::IDX_W-1:0]  lighter_row_o,
  input logic [mrop_pkg::CNT_W-1:0]  overlap_count_o,
  input logic [mrop_pkg::ROW_W-1:0]  common_mask_o
);

  import mrop_pkg::*;

  // A stalled result beat stays valid and holds its found flag, count and mask.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(overlap_count_o)
      && $stable(common_mask_o) && $stable(found_o))
    else $error("stalled result beat changed");

  // The shared-column mask and the overlap count agree.
  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(common_mask_o) == int'(overlap_count_o)))
    else $error("overlap count does not match common mask");

  // Found means a nonzero overlap.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o == (overlap_count_o != '0)))
    else $error("found flag does not match overlap count");

  // With no overlapping pair the whole result is zero.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> heavier_row_o == '0 && lighter_row_o == '0
      && common_mask_o == '0)
    else $error("empty result is not all zero");

  // The last row of a matrix starts a scan, so the next beat is stalled.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_row_i |=> in_stall_o)
    else $error("input taken right after a last row");

endmodule

bind max_row_overlap_pair_finder_unit mrop_checker u_mrop_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for max_row_overlap_pair_finder_unit.
// Streams random square bit matrices, predicts the best overlapping row pair
// and compares every result beat. Depends on mrop_pkg and the unit RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrop_pkg::*;

  localparam int unsigned MAX_ROWS    = 32;
  localparam int unsigned ROW_TARGET  = 900;     // stored rows before stimulus stops
  localparam int unsigned DRAIN_WAIT  = 600;     // drain wait, sized for the longest search (32 rows)
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned HOLD_LEN    = 800;     // long receiver hold-off, in cycles

  // One input beat: a matrix row plus the flag that closes the matrix.
  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic             is_last;
  } row_beat_t;

  // One result beat, in port order.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] heavier;
    logic [IDX_W-1:0] lighter;
    logic [CNT_W-1:0] count;
    logic [ROW_W-1:0] mask;
  } pair_result_t;

  // Receiver stall patterns; each one runs for a random stretch of cycles.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  // Every input of the unit starts at a known value at time zero.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [ROW_W-1:0] row_bits_i  = '0;
  logic             last_row_i  = 1'b0;
  logic             out_stall_i = 1'b0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic             found_o;
  logic [IDX_W-1:0] heavier_row_o;
  logic [IDX_W-1:0] lighter_row_o;
  logic [CNT_W-1:0] overlap_count_o;
  logic [ROW_W-1:0] common_mask_o;

  max_row_overlap_pair_finder_unit #(
    .MAX_N(MAX_ROWS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .row_bits_i     (row_bits_i),
    .last_row_i     (last_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .heavier_row_o  (heavier_row_o),
    .lighter_row_o  (lighter_row_o),
    .overlap_count_o(overlap_count_o),
    .common_mask_o  (common_mask_o)
  );

  // Stimulus and scoreboard storage.
  row_beat_t    row_beats_q[$];
  pair_result_t pair_expect_q[$];
  int unsigned  rows_queued   = 0;
  int unsigned  rows_accepted = 0;
  int unsigned  useful_rows   = 0;
  int unsigned  results_seen  = 0;
  int unsigned  fail_count    = 0;
  int unsigned  cycle_count   = 0;

  // The predictor keeps its own copy of the matrix being loaded.
  logic [ROW_W-1:0] matrix_rows[MAX_ROWS];
  int unsigned      rows_held = 0;

  // Driver, receiver and pressure state.
  row_beat_t   next_beat;
  logic        in_beat_done = 1'b0;
  int unsigned burst_left   = 1;
  int unsigned gap_left     = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int unsigned mode_left    = 0;
  int unsigned stall_phase  = 0;
  logic        pattern_stall;
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;
  int unsigned next_hold_at = 20;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Scan every pair i<j of the held rows in row-major order and keep the first
  // pair whose masked overlap is strictly larger than all earlier ones. Only
  // columns below the row count take part, so the matrix stays square.
  function automatic pair_result_t best_overlap(input int unsigned n);
    pair_result_t     res;
    logic [ROW_W-1:0] cols;
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] both;
    int unsigned      best;
    int unsigned      cnt;
    res  = '0;
    best = 0;
    cols = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    for (int unsigned i = 0; i < n; i++) begin
      a = matrix_rows[i] & cols;
      for (int unsigned j = i + 1; j < n; j++) begin
        b    = matrix_rows[j] & cols;
        both = a & b;
        cnt  = $countones(both);
        if (cnt > best) begin
          best = cnt;
          // The heavier row comes first; on equal weight the lower index wins.
          if ($countones(a) < $countones(b)) begin
            res.heavier = IDX_W'(j);
            res.lighter = IDX_W'(i);
          end else begin
            res.heavier = IDX_W'(i);
            res.lighter = IDX_W'(j);
          end
          res.mask = both;
        end
      end
    end
    res.found = (best > 0);
    res.count = CNT_W'(best);
    // With no shared column every field stays zero.
    if (!res.found) begin
      res = '0;
    end
    return res;
  endfunction

  // Update the predicted matrix with one accepted row beat. Rows beyond the
  // store depth are dropped, but a late last row still closes the matrix.
  task automatic absorb_row(input logic [ROW_W-1:0] bits, input logic is_last);
    if (rows_held < MAX_ROWS) begin
      matrix_rows[rows_held] = bits;
      rows_held++;
    end
    if (is_last) begin
      pair_expect_q.push_back(best_overlap(rows_held));
      rows_held = 0;
    end
  endtask

  task automatic note_failure(input string what, input pair_result_t want,
                              input pair_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s at cycle %0d: expected found=%0b heavier=%0d lighter=%0d count=%0d mask=%h",
               what, cycle_count, want.found, want.heavier, want.lighter,
               want.count, want.mask);
      $display("    actual found=%0b heavier=%0d lighter=%0d count=%0d mask=%h",
               got.found, got.heavier, got.lighter, got.count, got.mask);
    end
  endtask

  task automatic check_result();
    pair_result_t got;
    pair_result_t want;
    got = {found_o, heavier_row_o, lighter_row_o, overlap_count_o, common_mask_o};
    results_seen++;
    if (pair_expect_q.size() == 0) begin
      note_failure("Unexpected result beat", '0, got);
    end else begin
      want = pair_expect_q.pop_front();
      if (got.found !== want.found || got.heavier !== want.heavier ||
          got.lighter !== want.lighter || got.count !== want.count ||
          got.mask !== want.mask) begin
        note_failure("Result mismatch", want, got);
      end
    end
  endtask

  task automatic add_row(input logic [ROW_W-1:0] bits, input logic is_last);
    row_beats_q.push_back('{bits: bits, is_last: is_last});
    rows_queued++;
  endtask

  // Queue one matrix of n rows. Rows mix dense, sparse, single-column and
  // repeated content so that ties, empty overlaps and big overlaps all occur.
  // Columns outside the square always carry random junk to check the masking.
  task automatic add_random_matrix(input int unsigned n);
    logic [ROW_W-1:0] made[$];
    logic [ROW_W-1:0] cols;
    logic [ROW_W-1:0] r;
    int unsigned      top_col;
    cols    = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
    top_col = (n > ROW_W) ? ROW_W - 1 : n - 1;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0: r = $urandom;
        1: r = $urandom & $urandom & $urandom;
        2: r = (ROW_W'(1) << $urandom_range(0, top_col)) | ($urandom & ~cols);
        3: r = (made.size() != 0) ? made[$urandom_range(0, made.size() - 1)] : $urandom;
        default: r = $urandom | $urandom;
      endcase
      made.push_back(r);
      add_row(r, k == n - 1);
    end
    useful_rows += (n > MAX_ROWS) ? MAX_ROWS : n;
  endtask

  // Sampling at the rising edge: inputs and outputs only change at the
  // falling edge or after it, so the values seen here are settled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      in_beat_done <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        rows_accepted++;
        absorb_row(row_bits_i, last_row_i);
      end
      if (out_valid_o && !out_stall_i) begin
        check_result();
      end
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Input driver. A beat is held until it is taken; the next beat follows in
  // the same burst or after a random gap. Bursts end at random lengths.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_beat_done) begin
        if (gap_left != 0 || row_beats_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) begin
            gap_left <= gap_left - 1;
          end
        end else begin
          next_beat = row_beats_q.pop_front();
          row_bits_i <= next_beat.bits;
          last_row_i <= next_beat.is_last;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver stall pattern. The mode is redrawn when its random countdown runs
  // out, and STALL_NONE gives stretches where the pattern adds no stall.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        STALL_COIN:     pattern_stall = ($urandom_range(0, 1) != 0);
        STALL_PERIODIC: pattern_stall = (stall_phase % 3 == 0);
        STALL_HEAVY:    pattern_stall = ($urandom_range(0, 7) != 0);
        default:        pattern_stall = 1'b0;
      endcase
      out_stall_i <= (hold_left != 0) || pattern_stall;
    end
  end

  // Back pressure: twice during the run the receiver holds off for a long
  // stretch. The sender keeps offering rows, so the unit has to sit on a
  // finished result and stall its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && results_seen >= next_hold_at) begin
        hold_left    <= HOLD_LEN;
        holds_done   <= holds_done + 1;
        next_hold_at <= next_hold_at + 60;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;

    // Directed matrices first.
    // A lone row cannot form a pair, even when it is all ones.
    add_row(32'hFFFF_FFFF, 1'b1);
    // Two full rows: only columns 0 and 1 count; equal weight keeps row 0 first.
    add_row(32'hFFFF_FFFF, 1'b0);
    add_row(32'hFFFF_FFFF, 1'b1);
    // Three rows that share only columns outside the square: no pair found.
    add_row(32'hFFFF_FFF9, 1'b0);
    add_row(32'h0000_0002, 1'b0);
    add_row(32'hAAAA_AAA4, 1'b1);
    // The later row of the best pair is heavier, so it is reported first.
    add_row(32'h0000_0001, 1'b0);
    add_row(32'h0000_000F, 1'b0);
    add_row(32'h0000_0000, 1'b0);
    add_row(32'h0000_0000, 1'b1);
    // Three equal rows: later pairs only tie, so the first pair is kept.
    add_row(32'h0000_0003, 1'b0);
    add_row(32'h0000_0003, 1'b0);
    add_row(32'h0000_0003, 1'b1);
    // Two empty rows: no pair found.
    add_row(32'h0000_0000, 1'b0);
    add_row(32'h0000_0000, 1'b1);
    // Alternating columns: rows 0 and 2 share column 0 and column 2.
    add_row(32'h5555_5555, 1'b0);
    add_row(32'hAAAA_AAAA, 1'b0);
    add_row(32'h0000_0005, 1'b0);
    add_row(32'h0000_0008, 1'b1);
    useful_rows = rows_queued;

    // A full-width matrix and one with rows past the store depth, whose
    // last row still starts the search.
    add_random_matrix(MAX_ROWS);
    add_random_matrix(MAX_ROWS + 8);

    // Random matrices, mostly small so that the quadratic search stays short.
    while (useful_rows < ROW_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        n = $urandom_range(1, 8);
      end else if (pick < 97) begin
        n = $urandom_range(9, 20);
      end else begin
        n = $urandom_range(21, MAX_ROWS + 8);
      end
      add_random_matrix(n);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every row beat to be taken and every result to arrive, then
    // give the unit time to show any stray result.
    wait (rows_accepted == rows_queued);
    wait (pair_expect_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (fail_count == 0 && pair_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
